// ===== rtl/gblur_pkg.sv =====
// ----------------------------------------------------------------------------
// gblur_pkg
// Shared types, register indexes and constants of the 5x5 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gblur_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CHAN_W       = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int PIX_W        = NUM_CHANNELS * CHAN_W;
    localparam int POS_W        = 10;

    localparam int WIN        = 5;
    localparam int HALF_WIN   = WIN / 2;
    localparam int NUM_LINES  = WIN - 1;
    localparam int LINE_IDX_W = $clog2(NUM_LINES);
    localparam int ENTRY_W    = NUM_LINES * PIX_W;
    localparam int MIN_DIM    = 5;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_DIM_W   = 11;
    localparam int COEF_W      = 16;
    localparam int FRAC_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH           = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT          = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CORNER           = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_EDGE_NEAR_CORNER = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_EDGE_MIDDLE      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_INNER_DIAGONAL   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_INNER_CROSS      = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_CENTER           = 4'd7;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    // kernel weight classes
    localparam int NUM_CLASSES          = 6;
    localparam int CLS_CORNER           = 0;
    localparam int CLS_EDGE_NEAR_CORNER = 1;
    localparam int CLS_EDGE_MIDDLE      = 2;
    localparam int CLS_INNER_DIAGONAL   = 3;
    localparam int CLS_INNER_CROSS      = 4;
    localparam int CLS_CENTER           = 5;

    localparam logic [COEF_W-1:0] RST_COEF_CORNER           = 16'd33;
    localparam logic [COEF_W-1:0] RST_COEF_EDGE_NEAR_CORNER = 16'd328;
    localparam logic [COEF_W-1:0] RST_COEF_EDGE_MIDDLE      = 16'd714;
    localparam logic [COEF_W-1:0] RST_COEF_INNER_DIAGONAL   = 16'd3414;
    localparam logic [COEF_W-1:0] RST_COEF_INNER_CROSS      = 16'd7465;
    localparam logic [COEF_W-1:0] RST_COEF_CENTER           = 16'd16299;

    // datapath widths: up to eight pixels per class, 25 taps in total
    localparam int SUM_W  = CHAN_W + 3;
    localparam int PROD_W = SUM_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;

    // result queue
    localparam int OUT_DEPTH = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_start;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blur_red;
        logic [CHAN_W-1:0] blur_green;
        logic [CHAN_W-1:0] blur_blue;
        logic [POS_W-1:0]  center_row;
        logic [POS_W-1:0]  center_col;
        logic              frame_end;
    } blur_t;

    // weight class of tap (u, v) in the window
    function automatic int tap_class(input int u, input int v);
        int du;
        int dv;
        int cls;
        du = (u > HALF_WIN) ? u - HALF_WIN : HALF_WIN - u;
        dv = (v > HALF_WIN) ? v - HALF_WIN : HALF_WIN - v;
        if (du == 0 && dv == 0)
            cls = CLS_CENTER;
        else if (du + dv == 1)
            cls = CLS_INNER_CROSS;
        else if (du == 1 && dv == 1)
            cls = CLS_INNER_DIAGONAL;
        else if (du + dv == 2)
            cls = CLS_EDGE_MIDDLE;
        else if (du + dv == 3)
            cls = CLS_EDGE_NEAR_CORNER;
        else
            cls = CLS_CORNER;
        return cls;
    endfunction

endpackage

// ===== rtl/gblur_ram.sv =====
// ----------------------------------------------------------------------------
// gblur_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gaussian_blur_5x5_rgb_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb_top
// 5x5 Gaussian blur over an RGB pixel stream in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on pixel/pixel_valid/pixel_stall, one transfer per pixel, with
// frame_start on the first pixel of a frame. Results leave on
// blur/blur_valid/blur_stall, one per interior pixel, centered two rows and
// two columns behind the input; border pixels give no result.
// Frame size and the six Q0.16 weights are written over the cfg port
// (cfg_ready is always high); the user must write them while no pixel is in
// flight, as the block does not enforce it. Throughput is one pixel per
// clock while pixel_stall is low. The four previous lines share one RAM
// word per column, so each pixel costs one read and one write of that word.
// The RAM read starts with the input transfer; then come window shift, class
// sums, multiply, then accumulate and saturate into the queue for blur_valid.
// Results wait in an 8-entry queue; pixel_stall rises only when 8 results
// are accepted but not yet taken, so a stalled receiver does not stop the
// input until the queue would overflow.
// Reset restores the default registers, clears the window and the position
// counters and empties the queue. The line RAM is not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb_top
    import gblur_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pixel_t                 pixel,
    output logic                   blur_valid,
    input  logic                   blur_stall,
    output blur_t                  blur,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
    localparam int HDIM_W = (ROW_W + 1 > CFG_DIM_W) ? ROW_W + 1 : CFG_DIM_W;
    localparam int QPTR_W = $clog2(OUT_DEPTH);
    localparam int QCNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_end;
    } meta_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [COEF_W-1:0]    coef_reg [NUM_CLASSES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg                      <= RST_IMAGE_WIDTH;
            height_reg                     <= RST_IMAGE_HEIGHT;
            coef_reg[CLS_CORNER]           <= RST_COEF_CORNER;
            coef_reg[CLS_EDGE_NEAR_CORNER] <= RST_COEF_EDGE_NEAR_CORNER;
            coef_reg[CLS_EDGE_MIDDLE]      <= RST_COEF_EDGE_MIDDLE;
            coef_reg[CLS_INNER_DIAGONAL]   <= RST_COEF_INNER_DIAGONAL;
            coef_reg[CLS_INNER_CROSS]      <= RST_COEF_INNER_CROSS;
            coef_reg[CLS_CENTER]           <= RST_COEF_CENTER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:           width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT:          height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_COEF_CORNER:           coef_reg[CLS_CORNER] <= cfg_data;
                REG_COEF_EDGE_NEAR_CORNER: coef_reg[CLS_EDGE_NEAR_CORNER] <= cfg_data;
                REG_COEF_EDGE_MIDDLE:      coef_reg[CLS_EDGE_MIDDLE] <= cfg_data;
                REG_COEF_INNER_DIAGONAL:   coef_reg[CLS_INNER_DIAGONAL] <= cfg_data;
                REG_COEF_INNER_CROSS:      coef_reg[CLS_INNER_CROSS] <= cfg_data;
                REG_COEF_CENTER:           coef_reg[CLS_CENTER] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // clamped frame size
    logic [WDIM_W-1:0] width_ext;
    logic [WDIM_W-1:0] width_eff;
    logic [HDIM_W-1:0] height_ext;
    logic [HDIM_W-1:0] height_eff;

    assign width_ext  = WDIM_W'(width_reg);
    assign height_ext = HDIM_W'(height_reg);

    always_comb
    begin
        if (width_ext < WDIM_W'(MIN_DIM))
            width_eff = WDIM_W'(MIN_DIM);
        else if (width_ext > WDIM_W'(MAX_WIDTH))
            width_eff = WDIM_W'(MAX_WIDTH);
        else
            width_eff = width_ext;

        if (height_ext < HDIM_W'(MIN_DIM))
            height_eff = HDIM_W'(MIN_DIM);
        else if (height_ext > HDIM_W'(MAX_HEIGHT))
            height_eff = HDIM_W'(MAX_HEIGHT);
        else
            height_eff = height_ext;
    end

    // ------------------------------------------------------------------
    // input stage: position and line RAM read
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_start;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_start;
    logic [ROW_W-1:0]  row_cur;
    logic [WDIM_W-1:0] col_inc;
    logic [HDIM_W-1:0] row_inc;
    logic [HDIM_W-1:0] center_row_full;
    logic [WDIM_W-1:0] center_col_full;
    logic              line_done;
    logic              accept;
    logic              produce;
    meta_t             meta_cur;

    logic [QCNT_W-1:0] occ_reg;
    logic [QCNT_W-1:0] occ_next;

    assign pixel_stall = (occ_reg >= QCNT_W'(OUT_DEPTH));
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        col_start = pixel.frame_start ? '0 : col_reg;
        row_start = pixel.frame_start ? '0 : row_reg;
        col_cur   = (WDIM_W'(col_start) >= width_eff) ? '0 : col_start;
        row_cur   = (HDIM_W'(row_start) >= height_eff) ? '0 : row_start;

        col_inc   = WDIM_W'(col_cur) + WDIM_W'(1);
        row_inc   = HDIM_W'(row_cur) + HDIM_W'(1);
        line_done = (col_inc >= width_eff);

        if (line_done)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end

        produce = (HDIM_W'(row_cur) >= HDIM_W'(NUM_LINES))
               && (WDIM_W'(col_cur) >= WDIM_W'(NUM_LINES));

        center_row_full     = HDIM_W'(row_cur) - HDIM_W'(HALF_WIN);
        center_col_full     = WDIM_W'(col_cur) - WDIM_W'(HALF_WIN);
        meta_cur.center_row = center_row_full[POS_W-1:0];
        meta_cur.center_col = center_col_full[POS_W-1:0];
        meta_cur.frame_end  = (HDIM_W'(row_cur) == height_eff - HDIM_W'(1))
                           && (WDIM_W'(col_cur) == width_eff - WDIM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: line RAM data back, write back and window shift
    // ------------------------------------------------------------------
    logic                                  s1_valid_reg;
    logic                                  s1_produce_reg;
    logic [COL_W-1:0]                      s1_col_reg;
    logic [LINE_IDX_W-1:0]                 s1_slot_reg;
    logic [PIX_W-1:0]                      s1_pix_reg;
    meta_t                                 s1_meta_reg;
    logic                                  fwd_reg;
    logic [NUM_LINES-1:0][PIX_W-1:0]       fwd_data_reg;
    logic [ENTRY_W-1:0]                    ram_rdata;
    logic [NUM_LINES-1:0][PIX_W-1:0]       entry;
    logic [NUM_LINES-1:0][PIX_W-1:0]       wr_entry;
    logic [PIX_W-1:0]                      col_new [NUM_LINES];
    logic [PIX_W-1:0]                      win_reg [WIN][WIN];

    gblur_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    // a read issued while the previous pixel writes the same column sees old data
    always_comb
    begin
        entry    = fwd_reg ? fwd_data_reg : ram_rdata;
        wr_entry = entry;
        wr_entry[s1_slot_reg] = s1_pix_reg;
        for (int k = 0; k < NUM_LINES; k++)
        begin
            col_new[k] = entry[LINE_IDX_W'(s1_slot_reg + LINE_IDX_W'(k))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_reg      <= accept && s1_valid_reg && (s1_col_reg == col_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_produce_reg <= produce;
            s1_col_reg     <= col_cur;
            s1_slot_reg    <= row_cur[LINE_IDX_W-1:0];
            s1_pix_reg     <= {pixel.red, pixel.green, pixel.blue};
            s1_meta_reg    <= meta_cur;
        end
        fwd_data_reg <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < WIN; u++)
            begin
                for (int v = 0; v < WIN; v++)
                begin
                    win_reg[u][v] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int u = 0; u < WIN; u++)
            begin
                for (int v = 0; v < WIN - 1; v++)
                begin
                    win_reg[u][v] <= win_reg[u][v+1];
                end
            end
            for (int k = 0; k < NUM_LINES; k++)
            begin
                win_reg[k][WIN-1] <= col_new[k];
            end
            win_reg[WIN-1][WIN-1] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // stages a..c: class sums, products, accumulate
    // ------------------------------------------------------------------
    logic              a_valid_reg;
    meta_t             a_meta_reg;
    logic              b_valid_reg;
    meta_t             b_meta_reg;
    logic              c_valid_reg;
    meta_t             c_meta_reg;
    logic [SUM_W-1:0]  cls_sum    [NUM_CHANNELS][NUM_CLASSES];
    logic [SUM_W-1:0]  b_sum_reg  [NUM_CHANNELS][NUM_CLASSES];
    logic [PROD_W-1:0] c_prod_reg [NUM_CHANNELS][NUM_CLASSES];
    logic [ACC_W-1:0]  acc        [NUM_CHANNELS];
    logic [CHAN_W-1:0] chan_out   [NUM_CHANNELS];
    blur_t             result;

    // window taps grouped by weight class, per channel
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            for (int cl = 0; cl < NUM_CLASSES; cl++)
            begin
                cls_sum[ch][cl] = '0;
            end
        end
        for (int u = 0; u < WIN; u++)
        begin
            for (int v = 0; v < WIN; v++)
            begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    cls_sum[ch][tap_class(u, v)] = cls_sum[ch][tap_class(u, v)]
                        + SUM_W'(win_reg[u][v][(NUM_CHANNELS-1-ch)*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= s1_valid_reg && s1_produce_reg;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_meta_reg <= s1_meta_reg;
        b_meta_reg <= a_meta_reg;
        c_meta_reg <= b_meta_reg;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            for (int cl = 0; cl < NUM_CLASSES; cl++)
            begin
                b_sum_reg[ch][cl]  <= cls_sum[ch][cl];
                c_prod_reg[ch][cl] <= PROD_W'(b_sum_reg[ch][cl]) * PROD_W'(coef_reg[cl]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            acc[ch] = '0;
            for (int cl = 0; cl < NUM_CLASSES; cl++)
            begin
                acc[ch] = acc[ch] + ACC_W'(c_prod_reg[ch][cl]);
            end
            // drop the fraction, saturate at full scale
            if (acc[ch][ACC_W-1:FRAC_W] > (ACC_W-FRAC_W)'({CHAN_W{1'b1}}))
                chan_out[ch] = {CHAN_W{1'b1}};
            else
                chan_out[ch] = acc[ch][FRAC_W +: CHAN_W];
        end
        result.blur_red   = chan_out[0];
        result.blur_green = chan_out[1];
        result.blur_blue  = chan_out[2];
        result.center_row = c_meta_reg.center_row;
        result.center_col = c_meta_reg.center_col;
        result.frame_end  = c_meta_reg.frame_end;
    end

    // ------------------------------------------------------------------
    // result queue and credit count
    // ------------------------------------------------------------------
    blur_t             q_mem_reg [OUT_DEPTH];
    logic [QPTR_W-1:0] q_wr_reg;
    logic [QPTR_W-1:0] q_rd_reg;
    logic [QCNT_W-1:0] q_cnt_reg;
    logic [QCNT_W-1:0] q_cnt_next;
    logic              q_push;
    logic              q_pop;

    assign q_push     = c_valid_reg;
    assign blur_valid = (q_cnt_reg != '0);
    assign q_pop      = blur_valid && !blur_stall;
    assign blur       = q_mem_reg[q_rd_reg];

    // credits cover every accepted pixel that will give a result
    always_comb
    begin
        occ_next   = occ_reg + QCNT_W'(accept && produce) - QCNT_W'(q_pop);
        q_cnt_next = q_cnt_reg + QCNT_W'(q_push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            q_cnt_reg <= '0;
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            q_cnt_reg <= q_cnt_next;
            if (q_push)
            begin
                q_wr_reg <= (q_wr_reg == QPTR_W'(OUT_DEPTH - 1)) ? '0 : q_wr_reg + QPTR_W'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= (q_rd_reg == QPTR_W'(OUT_DEPTH - 1)) ? '0 : q_rd_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_reg] <= result;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= QCNT_W'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= occ_reg)
        else $error("queue holds more results than credits taken");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_produce_reg |-> ##3 c_valid_reg)
        else $error("interior pixel did not reach the result queue");

    a_forward_same_column: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg && $past(s1_valid_reg) && (s1_col_reg == $past(s1_col_reg)))
        else $error("forwarding used without a same-column write");

endmodule
